// File: hdl/pfra_pkg.sv
// Shared types and constants for the per-frame ring allocator.
package pfra_pkg;

    localparam int FRAMES     = 4;
    localparam int FRAME_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int ALIGN_BITS = 8;
    localparam int POS_W      = 24;
    localparam int CNT_W      = 25;

    localparam logic [CNT_W-1:0] REGION_MAX   = CNT_W'(1) << POS_W;
    localparam logic [CNT_W-1:0] REGION_RESET = CNT_W'(10485760);

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FRAME = 1'b1;

    typedef struct packed {
        logic             action;
        logic [1:0]       frame_index;
        logic [CNT_W-1:0] request_bytes;
    } t_in_word;

    typedef struct packed {
        logic             granted;
        logic [POS_W-1:0] offset;
        logic [CNT_W-1:0] granted_bytes;
    } t_out_word;

endpackage

// File: hdl/pfra_frame_mem.sv
// Per-frame byte counters: synchronous memory with per-entry valid bits.
module pfra_frame_mem
    import pfra_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [FRAME_W-1:0] i_rd_addr,
    output logic [CNT_W-1:0]   o_rd_data,
    input  logic               i_wr_en,
    input  logic [FRAME_W-1:0] i_wr_addr,
    input  logic [CNT_W-1:0]   i_wr_data
);

    logic [CNT_W-1:0] r_mem [FRAMES];
    logic [FRAMES-1:0] r_vld;
    logic [CNT_W-1:0] r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// File: hdl/per_frame_ring_allocator.sv
// Per-frame ring allocator over a configurable byte region.
// Each accepted word first reads its frame counter from the per-frame memory
// (a registered read), then in the execute state updates head, tail and the
// in-use total and writes the counter back; a new word is taken only once the
// previous one has left the execute state, so words never overlap. A result
// that is not taken holds the execute state until the output register frees
// up. All counters are cleared at reset; no clearing pass is needed.
module per_frame_ring_allocator
    import pfra_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_word
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic             r_state, n_state;
    logic [CNT_W-1:0] r_region;
    logic [POS_W-1:0] r_head, n_head;
    logic [POS_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_in_use, n_in_use;
    logic             r_act;
    logic [FRAME_W-1:0] r_frame;
    logic [CNT_W:0]   r_size;
    logic [CNT_W-1:0] r_total;
    logic             r_out_vld, n_out_vld;
    t_out_word        r_out, n_out;

    logic               w_in_acc;
    logic               w_go;
    logic [FRAME_W-1:0] w_frame;
    logic [CNT_W:0]     w_sum;
    logic [CNT_W-1:0]   w_fb;
    logic               w_wr_en;
    logic [CNT_W-1:0]   w_wr_data;

    logic [CNT_W-1:0] w_size;
    logic             w_big;
    logic [CNT_W-1:0] w_room;
    logic [CNT_W-1:0] w_to_end;
    logic             w_grant;
    logic             w_wrap;
    logic [POS_W-1:0] w_off;
    logic [CNT_W-1:0] w_nh_sum;
    logic [CNT_W-1:0] w_nh;
    logic [CNT_W-1:0] w_charge;
    logic [CNT_W:0]   w_nt_sum;
    logic [CNT_W:0]   w_nt;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_go        = (r_state == ST_EXEC) && (!r_out_vld || i_out_ready);
    assign w_frame     = i_in_word.frame_index[FRAME_W-1:0];
    assign w_sum       = {1'b0, i_in_word.request_bytes} + (CNT_W+1)'((1 << ALIGN_BITS) - 1);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    pfra_frame_mem u_frame_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (w_frame),
        .o_rd_data (w_fb),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_frame),
        .i_wr_data (w_wr_data)
    );

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_act   <= i_in_word.action;
            r_frame <= w_frame;
            r_size  <= {w_sum[CNT_W:ALIGN_BITS], ALIGN_BITS'(0)};
            r_total <= (r_region > REGION_MAX) ? REGION_MAX : r_region;
        end
        if (w_go) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        w_size   = r_size[CNT_W-1:0];
        w_big    = r_size > {1'b0, r_total};
        w_room   = {1'b0, r_tail - r_head};
        w_to_end = ({1'b0, r_head} < r_total) ? r_total - {1'b0, r_head} : '0;
        w_grant  = 1'b0;
        w_wrap   = 1'b0;
        if (w_big) begin
            w_grant = 1'b0;
        end else if (r_tail > r_head) begin
            w_grant = w_size <= w_room;
        end else if (r_tail < r_head) begin
            if (w_size <= w_to_end) begin
                w_grant = 1'b1;
            end else begin
                w_wrap  = 1'b1;
                w_grant = (r_tail != '0) && (w_size <= {1'b0, r_tail});
            end
        end else begin
            w_grant = (r_in_use == '0);
        end
        w_off    = w_wrap ? '0 : r_head;
        w_nh_sum = {1'b0, w_off} + w_size;
        w_nh     = (w_nh_sum >= r_total) ? w_nh_sum - r_total : w_nh_sum;
        w_charge = (w_wrap ? w_to_end : '0) + (w_grant ? w_size : '0);
        w_nt_sum = {2'b0, r_tail} + {1'b0, w_fb};
        w_nt     = (w_nt_sum >= {1'b0, r_total}) ? w_nt_sum - {1'b0, r_total} : w_nt_sum;

        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_in_use  = r_in_use;
        n_out_vld = r_out_vld && !i_out_ready;
        n_out     = '0;
        w_wr_en   = 1'b0;
        w_wr_data = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_go) begin
                    n_state   = ST_IDLE;
                    n_out_vld = 1'b1;
                    if (r_act == ACT_FRAME) begin
                        if (w_fb != '0) begin
                            n_tail    = w_nt[POS_W-1:0];
                            n_in_use  = (r_in_use >= w_fb) ? r_in_use - w_fb : '0;
                            w_wr_en   = 1'b1;
                            w_wr_data = '0;
                        end
                    end else begin
                        if (w_grant) begin
                            n_head = w_nh[POS_W-1:0];
                        end else if (w_wrap) begin
                            n_head = '0;
                        end
                        n_in_use  = r_in_use + w_charge;
                        w_wr_en   = w_grant || w_wrap;
                        w_wr_data = w_fb + w_charge;
                        n_out.granted       = w_grant;
                        n_out.offset        = w_grant ? w_off : '0;
                        n_out.granted_bytes = w_grant ? w_size : '0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_region  <= REGION_RESET;
            r_head    <= '0;
            r_tail    <= '0;
            r_in_use  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_region <= i_cfg_data;
            end
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_in_use  <= n_in_use;
            r_out_vld <= n_out_vld;
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("input taken while a word is in execution");

    a_idle_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.granted) |->
            (o_out_word.offset == '0 && o_out_word.granted_bytes == '0))
        else $error("refused result carries offset or size");

    a_hold_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && o_out_valid && !i_out_ready) |=>
            (r_state == ST_EXEC && $stable(o_out_word)))
        else $error("execute cycle left while result register is blocked");
`endif

endmodule
